[sv/hfr_pkg.sv]
// shared types and constants of the frame receiver
package hfr_pkg;

   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;
   localparam logic [7:0] START_SHORT_M2S = 8'h02;
   localparam logic [7:0] START_SHORT_S2M = 8'h06;
   localparam logic [7:0] START_LONG_M2S = 8'h82;
   localparam logic [7:0] START_LONG_S2M = 8'h86;
   localparam logic [4:0] PREAMBLE_MAX = 5'd31;
   localparam logic [2:0] LAST_LONG_STEP = 3'd4;

   // register indexes on the csr port
   localparam logic REG_DEVICE_ID = 1'b0;
   localparam logic REG_MIN_PREAMBLES = 1'b1;

   localparam logic [7:0] DEVICE_ID_RESET = 8'd0;
   localparam logic [4:0] MIN_PREAMBLES_RESET = 5'd2;

   typedef enum logic {
      CMD_BYTE    = 1'b0,
      CMD_TIMEOUT = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      ST_HUNTING   = 3'd0,
      ST_IN_FRAME  = 3'd1,
      ST_OK        = 3'd2,
      ST_ERR_PREAM = 3'd3,
      ST_ERR_START = 3'd4,
      ST_ERR_ADDR  = 3'd5,
      ST_ERR_CSUM  = 3'd6,
      ST_ERR_TMO   = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_ADDR = 3'd1,
      PH_CMD  = 3'd2,
      PH_LEN  = 3'd3,
      PH_DATA = 3'd4,
      PH_CSUM = 3'd5
   } phase_type;

endpackage

[sv/hfr_channels.sv]
// valid/ready channel interfaces for received bytes and parse results

interface hfr_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] rx_byte;

   modport source (output valid, output command, output rx_byte, input ready);
   modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface hfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic       data_valid;
   logic [7:0] data_byte;
   logic [7:0] data_index;
   logic [7:0] frame_command;
   logic [7:0] data_length;
   logic       master_to_slave;
   logic       short_frame;
   logic       primary_master;

   modport source (
      output valid, output status, output data_valid, output data_byte,
      output data_index, output frame_command, output data_length,
      output master_to_slave, output short_frame, output primary_master,
      input ready
   );
   modport sink (
      input valid, input status, input data_valid, input data_byte,
      input data_index, input frame_command, input data_length,
      input master_to_slave, input short_frame, input primary_master,
      output ready
   );
endinterface

[sv/hart_frame_receiver.sv]
// byte-serial frame receiver: preamble, start character, address, payload, checksum
// each accepted item's result is registered in the output register
// throughput: one item per cycle; a new item is taken whenever the output register
//   is empty or is being read in the same cycle
// reset (synchronous, active high) returns the parser to preamble hunting, clears
//   the frame fields and loads the register defaults (device id 0, two preambles)
module hart_frame_receiver (
   input  logic                       clock,
   input  logic                       reset,
   hfr_req_if.sink                    req_if,
   hfr_rsp_if.source                  rsp_if,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [hfr_pkg::PADDR_W-1:0] paddr,
   input  logic [hfr_pkg::PDATA_W-1:0] pwdata,
   output logic [hfr_pkg::PDATA_W-1:0] prdata,
   output logic                       pready
);

   // configuration registers
   logic [7:0] dev_id_ff;
   logic [4:0] min_pre_ff;

   // parser state
   hfr_pkg::phase_type phase_ff, phase_in;
   logic [4:0] pre_cnt_ff, pre_cnt_in;
   logic [2:0] step_ff, step_in;
   logic       miss_ff, miss_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] len_ff, len_in;
   logic       m2s_ff, m2s_in;
   logic       short_ff, short_in;
   logic       prim_ff, prim_in;

   // output register
   logic                   rsp_valid_ff;
   hfr_pkg::status_type    status_ff, status_in;
   logic                   dv_ff, dv_in;
   logic [7:0]             db_ff, db_in;
   logic [7:0]             di_ff, di_in;

   logic       accept;
   logic       cfg_write;
   logic       cfg_index;
   logic [7:0] b;
   logic       addr_last;
   logic       addr_bad;
   logic [7:0] left_dec;

   // ---------------------------------------------------------------- csr port
   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;
   assign cfg_index = paddr[2];

   always_comb begin
      case (cfg_index)
         hfr_pkg::REG_DEVICE_ID:     prdata = {{(hfr_pkg::PDATA_W-8){1'b0}}, dev_id_ff};
         hfr_pkg::REG_MIN_PREAMBLES: prdata = {{(hfr_pkg::PDATA_W-5){1'b0}}, min_pre_ff};
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_id_ff  <= hfr_pkg::DEVICE_ID_RESET;
         min_pre_ff <= hfr_pkg::MIN_PREAMBLES_RESET;
      end else if (cfg_write) begin
         if (cfg_index == hfr_pkg::REG_DEVICE_ID) begin
            dev_id_ff <= pwdata[7:0];
         end else begin
            min_pre_ff <= pwdata[4:0];
         end
      end
   end

   // ---------------------------------------------------------------- handshake
   // the output register frees up when empty or read this cycle
   assign req_if.ready = ~rsp_valid_ff | rsp_if.ready;
   assign accept       = req_if.valid & req_if.ready;
   assign b            = req_if.rx_byte;
   assign left_dec     = left_ff - 8'd1;

   // address checks for the byte in hand
   always_comb begin
      addr_bad  = 1'b0;
      addr_last = 1'b0;
      if (short_ff) begin
         addr_bad  = ({4'b0000, b[3:0]} != dev_id_ff);
         addr_last = 1'b1;
      end else begin
         if ((step_ff == 3'd2 || step_ff == 3'd3) && b != 8'd0) begin
            addr_bad = 1'b1;
         end
         if (step_ff >= hfr_pkg::LAST_LONG_STEP && b != dev_id_ff) begin
            addr_bad = 1'b1;
         end
         addr_last = (step_ff >= hfr_pkg::LAST_LONG_STEP);
      end
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      phase_in   = phase_ff;
      pre_cnt_in = pre_cnt_ff;
      step_in    = step_ff;
      miss_in    = miss_ff;
      xor_in     = xor_ff;
      left_in    = left_ff;
      cmd_in     = cmd_ff;
      len_in     = len_ff;
      m2s_in     = m2s_ff;
      short_in   = short_ff;
      prim_in    = prim_ff;
      status_in  = hfr_pkg::ST_IN_FRAME;
      dv_in      = 1'b0;
      db_in      = 8'd0;
      di_in      = 8'd0;

      if (req_if.command == hfr_pkg::CMD_TIMEOUT) begin
         if (phase_ff == hfr_pkg::PH_HUNT) begin
            pre_cnt_in = 5'd0;
            status_in  = hfr_pkg::ST_HUNTING;
         end else begin
            // abort the frame in progress
            status_in  = hfr_pkg::ST_ERR_TMO;
            phase_in   = hfr_pkg::PH_HUNT;
            pre_cnt_in = 5'd0;
            step_in    = 3'd0;
            miss_in    = 1'b0;
            left_in    = 8'd0;
         end
      end else begin
         case (phase_ff)
            hfr_pkg::PH_HUNT: begin
               if (b == hfr_pkg::PREAMBLE_BYTE) begin
                  // preamble count saturates
                  if (pre_cnt_ff != hfr_pkg::PREAMBLE_MAX) begin
                     pre_cnt_in = pre_cnt_ff + 5'd1;
                  end
                  status_in = hfr_pkg::ST_HUNTING;
               end else if (pre_cnt_ff < min_pre_ff) begin
                  status_in  = hfr_pkg::ST_ERR_PREAM;
                  pre_cnt_in = 5'd0;
               end else if (b == hfr_pkg::START_SHORT_M2S || b == hfr_pkg::START_SHORT_S2M ||
                            b == hfr_pkg::START_LONG_M2S || b == hfr_pkg::START_LONG_S2M) begin
                  // start character: bit 7 marks long frames, bit 2 slave-to-master
                  m2s_in     = ~b[2];
                  short_in   = ~b[7];
                  prim_in    = 1'b0;
                  cmd_in     = 8'd0;
                  len_in     = 8'd0;
                  xor_in     = b;
                  step_in    = 3'd0;
                  miss_in    = 1'b0;
                  pre_cnt_in = 5'd0;
                  phase_in   = hfr_pkg::PH_ADDR;
               end else begin
                  status_in  = hfr_pkg::ST_ERR_START;
                  pre_cnt_in = 5'd0;
               end
            end
            hfr_pkg::PH_ADDR: begin
               xor_in = xor_ff ^ b;
               if (step_ff == 3'd0 && b[7]) begin
                  prim_in = 1'b1;
               end
               if (addr_last) begin
                  if (miss_ff | addr_bad) begin
                     status_in  = hfr_pkg::ST_ERR_ADDR;
                     phase_in   = hfr_pkg::PH_HUNT;
                     pre_cnt_in = 5'd0;
                     step_in    = 3'd0;
                     miss_in    = 1'b0;
                     left_in    = 8'd0;
                  end else begin
                     step_in  = 3'd0;
                     phase_in = hfr_pkg::PH_CMD;
                  end
               end else begin
                  miss_in = miss_ff | addr_bad;
                  step_in = step_ff + 3'd1;
               end
            end
            hfr_pkg::PH_CMD: begin
               xor_in   = xor_ff ^ b;
               cmd_in   = b;
               phase_in = hfr_pkg::PH_LEN;
            end
            hfr_pkg::PH_LEN: begin
               xor_in   = xor_ff ^ b;
               len_in   = b;
               left_in  = b;
               phase_in = (b == 8'd0) ? hfr_pkg::PH_CSUM : hfr_pkg::PH_DATA;
            end
            hfr_pkg::PH_DATA: begin
               xor_in  = xor_ff ^ b;
               dv_in   = 1'b1;
               db_in   = b;
               di_in   = len_ff - left_ff;
               left_in = left_dec;
               if (left_dec == 8'd0) begin
                  phase_in = hfr_pkg::PH_CSUM;
               end
            end
            default: begin
               // checksum byte closes the frame
               status_in  = (b == xor_ff) ? hfr_pkg::ST_OK : hfr_pkg::ST_ERR_CSUM;
               phase_in   = hfr_pkg::PH_HUNT;
               pre_cnt_in = 5'd0;
               step_in    = 3'd0;
               miss_in    = 1'b0;
               left_in    = 8'd0;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= hfr_pkg::PH_HUNT;
         pre_cnt_ff <= 5'd0;
         step_ff    <= 3'd0;
         miss_ff    <= 1'b0;
         xor_ff     <= 8'd0;
         left_ff    <= 8'd0;
         cmd_ff     <= 8'd0;
         len_ff     <= 8'd0;
         m2s_ff     <= 1'b0;
         short_ff   <= 1'b0;
         prim_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         pre_cnt_ff <= pre_cnt_in;
         step_ff    <= step_in;
         miss_ff    <= miss_in;
         xor_ff     <= xor_in;
         left_ff    <= left_in;
         cmd_ff     <= cmd_in;
         len_ff     <= len_in;
         m2s_ff     <= m2s_in;
         short_ff   <= short_in;
         prim_ff    <= prim_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         dv_ff     <= dv_in;
         db_ff     <= db_in;
         di_ff     <= di_in;
      end
   end

   // ---------------------------------------------------------------- result
   // frame fields come straight from the state: it only moves when the
   // output register reloads, so they always match the item on display
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.status          = status_ff;
   assign rsp_if.data_valid      = dv_ff;
   assign rsp_if.data_byte       = db_ff;
   assign rsp_if.data_index      = di_ff;
   assign rsp_if.frame_command   = cmd_ff;
   assign rsp_if.data_length     = len_ff;
   assign rsp_if.master_to_slave = m2s_ff;
   assign rsp_if.short_frame     = short_ff;
   assign rsp_if.primary_master  = prim_ff;

endmodule

[dv/hfr_result_checker.sv]
// checker for the frame receiver: tracks the parse state, predicts each result and compares it
`timescale 1ns / 100ps

module hfr_result_checker
   import hfr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   hfr_req_if                 req_mon,
   hfr_rsp_if                 rsp_mon,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic               pready,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output int                 mismatches,
   output int                 pending
);

   typedef struct packed {
      status_type status;
      logic       data_valid;
      logic [7:0] data_byte;
      logic [7:0] data_index;
      logic [7:0] frame_command;
      logic [7:0] data_length;
      logic       master_to_slave;
      logic       short_frame;
      logic       primary_master;
   } result_type;

   // register copies
   logic [7:0] dev_id;
   logic [4:0] min_pre;

   // parser copy
   phase_type  phase;
   logic [4:0] pre_cnt;
   logic [2:0] addr_step;
   logic       addr_bad;
   logic [7:0] xor_acc;
   logic [7:0] left;
   logic [7:0] cmd_hold;
   logic [7:0] len_hold;
   logic       m2s, sf, pm;

   result_type expected_results[$];
   int         mismatch_count = 0;
   int         result_count = 0;

   assign mismatches = mismatch_count;

   initial pending = 0;

   task automatic report_mismatch(input string what, input logic [7:0] want,
                                  input logic [7:0] got);
      mismatch_count++;
      $display("mismatch at result %0d: %s expected %0h got %0h", result_count, what,
               want, got);
   endtask

   task automatic restart_hunt();
      phase = PH_HUNT;
      pre_cnt = '0;
      addr_step = '0;
      addr_bad = 1'b0;
      left = '0;
   endtask

   task automatic advance_parser(input logic ev, input logic [7:0] b,
                                 output result_type r);
      logic last;
      r = '0;
      r.status = ST_IN_FRAME;
      if (ev == CMD_TIMEOUT) begin
         if (phase == PH_HUNT) begin
            pre_cnt = '0;
            r.status = ST_HUNTING;
         end else begin
            r.status = ST_ERR_TMO;
            restart_hunt();
         end
      end else begin
         case (phase)
            PH_HUNT: begin
               if (b == PREAMBLE_BYTE) begin
                  if (pre_cnt < PREAMBLE_MAX) pre_cnt = pre_cnt + 5'd1;
                  r.status = ST_HUNTING;
               end else if (pre_cnt < min_pre) begin
                  r.status = ST_ERR_PREAM;
                  pre_cnt = '0;
               end else if (b == START_SHORT_M2S || b == START_SHORT_S2M ||
                            b == START_LONG_M2S || b == START_LONG_S2M) begin
                  m2s = (b == START_SHORT_M2S) || (b == START_LONG_M2S);
                  sf = (b == START_SHORT_M2S) || (b == START_SHORT_S2M);
                  pm = 1'b0;
                  cmd_hold = '0;
                  len_hold = '0;
                  xor_acc = b;
                  addr_step = '0;
                  addr_bad = 1'b0;
                  pre_cnt = '0;
                  phase = PH_ADDR;
               end else begin
                  r.status = ST_ERR_START;
                  pre_cnt = '0;
               end
            end
            PH_ADDR: begin
               xor_acc = xor_acc ^ b;
               if (addr_step == 3'd0 && b[7]) pm = 1'b1;
               if (sf) begin
                  if ({4'h0, b[3:0]} != dev_id) addr_bad = 1'b1;
                  last = 1'b1;
               end else begin
                  if ((addr_step == 3'd2 || addr_step == 3'd3) && b != 8'h00) addr_bad = 1'b1;
                  if (addr_step >= LAST_LONG_STEP && b != dev_id) addr_bad = 1'b1;
                  last = (addr_step >= LAST_LONG_STEP);
               end
               if (last) begin
                  if (addr_bad) begin
                     r.status = ST_ERR_ADDR;
                     restart_hunt();
                  end else begin
                     addr_step = '0;
                     phase = PH_CMD;
                  end
               end else begin
                  addr_step = addr_step + 3'd1;
               end
            end
            PH_CMD: begin
               xor_acc = xor_acc ^ b;
               cmd_hold = b;
               phase = PH_LEN;
            end
            PH_LEN: begin
               xor_acc = xor_acc ^ b;
               len_hold = b;
               left = b;
               phase = (b == 8'h00) ? PH_CSUM : PH_DATA;
            end
            PH_DATA: begin
               xor_acc = xor_acc ^ b;
               r.data_valid = 1'b1;
               r.data_byte = b;
               r.data_index = len_hold - left;
               left = left - 8'd1;
               if (left == 8'h00) phase = PH_CSUM;
            end
            default: begin
               r.status = (b == xor_acc) ? ST_OK : ST_ERR_CSUM;
               restart_hunt();
            end
         endcase
      end
      r.frame_command = cmd_hold;
      r.data_length = len_hold;
      r.master_to_slave = m2s;
      r.short_frame = sf;
      r.primary_master = pm;
   endtask

   always @(posedge clock) begin
      result_type want, got;
      if (reset) begin
         dev_id = DEVICE_ID_RESET;
         min_pre = MIN_PREAMBLES_RESET;
         restart_hunt();
         xor_acc = '0;
         cmd_hold = '0;
         len_hold = '0;
         m2s = 1'b0;
         sf = 1'b0;
         pm = 1'b0;
         expected_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_DEVICE_ID) dev_id = pwdata[7:0];
            else min_pre = pwdata[4:0];
         end
         // a result leaves only after its item has been registered, so compare before predicting
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status = status_type'(rsp_mon.status);
            got.data_valid = rsp_mon.data_valid;
            got.data_byte = rsp_mon.data_byte;
            got.data_index = rsp_mon.data_index;
            got.frame_command = rsp_mon.frame_command;
            got.data_length = rsp_mon.data_length;
            got.master_to_slave = rsp_mon.master_to_slave;
            got.short_frame = rsp_mon.short_frame;
            got.primary_master = rsp_mon.primary_master;
            if (expected_results.size() == 0) begin
               report_mismatch("result with no item waiting", 8'h00, 8'(got.status));
            end else begin
               want = expected_results.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", 8'(want.status), 8'(got.status));
               if (got.data_valid != want.data_valid)
                  report_mismatch("data_valid", 8'(want.data_valid), 8'(got.data_valid));
               if (got.data_byte != want.data_byte)
                  report_mismatch("data_byte", want.data_byte, got.data_byte);
               if (got.data_index != want.data_index)
                  report_mismatch("data_index", want.data_index, got.data_index);
               if (got.frame_command != want.frame_command)
                  report_mismatch("frame_command", want.frame_command, got.frame_command);
               if (got.data_length != want.data_length)
                  report_mismatch("data_length", want.data_length, got.data_length);
               if (got.master_to_slave != want.master_to_slave)
                  report_mismatch("master_to_slave", 8'(want.master_to_slave),
                                  8'(got.master_to_slave));
               if (got.short_frame != want.short_frame)
                  report_mismatch("short_frame", 8'(want.short_frame), 8'(got.short_frame));
               if (got.primary_master != want.primary_master)
                  report_mismatch("primary_master", 8'(want.primary_master),
                                  8'(got.primary_master));
            end
            result_count++;
         end
         if (req_mon.valid && req_mon.ready) begin
            advance_parser(req_mon.command, req_mon.rx_byte, want);
            expected_results.push_back(want);
         end
      end
      pending <= expected_results.size();
   end

endmodule

[dv/hart_frame_receiver_test.sv]
// top of the frame receiver testbench: clock, reset, register writes, byte stimulus, verdict
`timescale 1ns / 100ps

module hart_frame_receiver_test;
   import hfr_pkg::*;

   localparam int ITEMS_PER_SEG = 230;      // eight settings, about 1850 random items
   localparam int CYCLE_LIMIT = 400000;     // far above the slowest legal run

   logic clock = 1'b0;
   logic reset = 1'b1;

   // configuration port
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [PDATA_W-1:0] pwdata = '0;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   hfr_req_if req_ch ();
   hfr_rsp_if rsp_ch ();

   int mismatches;
   int pending;

   // idle percentages of the sender and the receiver
   int src_idle_pct = 18;
   int sink_idle_pct = 87;

   // stimulus view of the registers
   logic [7:0] dev_id = DEVICE_ID_RESET;
   logic [4:0] min_pre = MIN_PREAMBLES_RESET;

   logic [8:0] burst_q[$];   // {command, rx_byte} items waiting to be sent
   logic [7:0] frame_xor;
   int         sent_items = 0;
   int         cycle_count = 0;

   hart_frame_receiver DUT (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_ch.sink),
      .rsp_if  (rsp_ch.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   hfr_result_checker result_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always #2 clock = ~clock;

   // receiver stalls at random, changed on the falling edge only
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // one item: optional idle gap, then hold it until the block takes it
   task automatic send_item(input logic cmd, input logic [7:0] b);
      while ($urandom_range(99) < src_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_items++;
   endtask

   task automatic send_burst();
      foreach (burst_q[i]) send_item(burst_q[i][8], burst_q[i][7:0]);
      burst_q.delete();
   endtask

   // received byte, folded into the frame checksum
   task automatic queue_byte(input logic [7:0] b);
      burst_q.push_back({CMD_BYTE, b});
      frame_xor = frame_xor ^ b;
   endtask

   // sender stops until every result is back, then a short settle
   task automatic wait_for_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // apb write: setup cycle, then access cycle
   task automatic write_register(input logic idx, input logic [PDATA_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == REG_DEVICE_ID) dev_id = value[7:0];
      else min_pre = value[4:0];
   endtask

   // preambles, start character, address, command, length, data, checksum
   task automatic queue_frame(input int n_pre, input logic [7:0] start, input bit bad_addr,
                              input int len, input bit bad_csum);
      logic [7:0] addr[5];
      logic [7:0] csum;
      int         n_addr;
      int         spoil;
      repeat (n_pre) queue_byte(PREAMBLE_BYTE);
      frame_xor = 8'h00;
      queue_byte(start);
      foreach (addr[i]) addr[i] = 8'($urandom_range(255));
      if (start == START_SHORT_M2S || start == START_SHORT_S2M) begin
         n_addr = 1;
         addr[0][3:0] = dev_id[3:0];
         if (bad_addr) addr[0][3:0] = addr[0][3:0] ^ 4'($urandom_range(1, 15));
      end else begin
         n_addr = 5;
         addr[2] = 8'h00;
         addr[3] = 8'h00;
         addr[4] = dev_id;
         if (bad_addr) begin
            spoil = $urandom_range(2, 4);
            addr[spoil] = addr[spoil] ^ 8'($urandom_range(1, 255));
         end
      end
      for (int i = 0; i < n_addr; i++) queue_byte(addr[i]);
      queue_byte(8'($urandom_range(255)));
      queue_byte(8'(len));
      repeat (len) queue_byte(8'($urandom_range(255)));
      csum = frame_xor;
      if (bad_csum) csum = csum ^ 8'($urandom_range(1, 255));
      queue_byte(csum);
   endtask

   function automatic logic [7:0] pick_start();
      case ($urandom_range(3))
         0: pick_start = START_SHORT_M2S;
         1: pick_start = START_SHORT_S2M;
         2: pick_start = START_LONG_M2S;
         default: pick_start = START_LONG_S2M;
      endcase
   endfunction

   // one random burst: mostly a frame, else too few preambles, a bad start character or line noise
   task automatic queue_random_burst();
      int         pick;
      int         n_pre;
      int         len;
      logic [7:0] b;
      pick = $urandom_range(99);
      // usual preamble run, now and then long enough to saturate the count
      n_pre = min_pre + $urandom_range(0, 3);
      if ($urandom_range(99) < 3) n_pre = 31 + $urandom_range(0, 6);
      len = $urandom_range(0, 6);
      if ($urandom_range(99) < 10) len = $urandom_range(7, 40);
      if ($urandom_range(199) == 0) len = $urandom_range(128, 255);
      if (pick < 70 || (pick < 80 && min_pre == 0)) begin
         queue_frame(n_pre, pick_start(), $urandom_range(99) < 10, len,
                     $urandom_range(99) < 10);
      end else if (pick < 80) begin
         // too few preambles before the start character
         queue_frame($urandom_range(0, min_pre - 1), pick_start(), 1'b0, len, 1'b0);
      end else if (pick < 88) begin
         // unknown start character after a valid preamble run
         do b = 8'($urandom_range(255));
         while (b == PREAMBLE_BYTE || b == START_SHORT_M2S || b == START_SHORT_S2M ||
                b == START_LONG_M2S || b == START_LONG_S2M);
         repeat (n_pre) queue_byte(PREAMBLE_BYTE);
         queue_byte(b);
      end else begin
         // noise: stray bytes and timeouts
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(3) == 0) burst_q.push_back({CMD_TIMEOUT, 8'($urandom_range(255))});
            else queue_byte(8'($urandom_range(255)));
         end
      end
      // a timeout dropped at some point of the burst aborts whatever is in progress
      if ($urandom_range(99) < 8)
         burst_q.insert($urandom_range(0, burst_q.size() - 1),
                        {CMD_TIMEOUT, 8'($urandom_range(255))});
   endtask

   initial begin
      logic [7:0] seg_dev[8];
      int         seg_min[8];
      int         seg_start;
      // drive every input before reset releases
      req_ch.valid = 1'b0;
      req_ch.command = CMD_BYTE;
      req_ch.rx_byte = 8'h00;
      rsp_ch.ready = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset settings (id 0, two preambles)
      queue_byte(8'h00);                    // no preamble at all
      queue_byte(PREAMBLE_BYTE);
      queue_byte(PREAMBLE_BYTE);
      queue_byte(8'h55);                    // unknown start character
      queue_byte(PREAMBLE_BYTE);
      burst_q.push_back({CMD_TIMEOUT, 8'hFF});  // timeout while hunting
      send_burst();
      // short master frame, primary bit set, command 0xff, one data byte
      queue_byte(PREAMBLE_BYTE);
      queue_byte(PREAMBLE_BYTE);
      frame_xor = 8'h00;
      queue_byte(START_SHORT_M2S);
      queue_byte(8'h80);
      queue_byte(8'hFF);
      queue_byte(8'h01);
      queue_byte(8'hAA);
      queue_byte(frame_xor);
      send_burst();
      // long slave frame, all-zero address, zero length, bad checksum
      queue_byte(PREAMBLE_BYTE);
      queue_byte(PREAMBLE_BYTE);
      frame_xor = 8'h00;
      queue_byte(START_LONG_S2M);
      repeat (5) queue_byte(8'h00);
      queue_byte(8'h00);
      queue_byte(8'h00);
      queue_byte(frame_xor ^ 8'h01);
      send_burst();

      // register settings per segment, extremes first
      seg_dev = '{8'd3, 8'd255, 8'd0, 8'd15, 8'd0, 8'd0, 8'd0, 8'd0};
      seg_min = '{1, 20, 0, 31, 0, 0, 0, 0};
      for (int s = 4; s < 8; s++) begin
         seg_dev[s] = ($urandom_range(9) == 0) ? 8'($urandom_range(16, 255))
                                                : 8'($urandom_range(15));
         seg_min[s] = $urandom_range(1, 20);
      end

      for (int s = 0; s < 8; s++) begin
         // registers change only with nothing in flight
         wait_for_results();
         write_register(REG_DEVICE_ID, PDATA_W'(seg_dev[s]));
         write_register(REG_MIN_PREAMBLES, seg_min[s]);
         if (s < 3) begin
            src_idle_pct = 18;
            sink_idle_pct = 87;
         end else if (s < 6) begin
            src_idle_pct = 87;
            sink_idle_pct = 18;
         end else begin
            src_idle_pct = 0;
            sink_idle_pct = 0;
         end
         seg_start = sent_items;
         while (sent_items - seg_start < ITEMS_PER_SEG) begin
            queue_random_burst();
            send_burst();
         end
      end

      // drain, then let anything stray arrive before the verdict
      wait_for_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

[filelist.f]
sv/hfr_pkg.sv
sv/hfr_channels.sv
sv/hart_frame_receiver.sv
dv/hfr_result_checker.sv
dv/hart_frame_receiver_test.sv
